@@ rtl/core/sha1_stream_hasher_assert.svh @@
// Assertion macros used by the SHA-1 stream hasher top level.
`ifndef SHA1_STREAM_HASHER_ASSERT_SVH
`define SHA1_STREAM_HASHER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SHA1_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SHA1_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/sha1_pkg.sv @@
// Types, constants and helper functions shared by the SHA-1 hasher modules.
package sha1_pkg;

  typedef logic [4:0][31:0] chain_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_ROUND,
    S_FOLD,
    S_EMIT
  } state_t;

  typedef enum logic [1:0] {
    STG_CH,
    STG_PAR0,
    STG_MAJ,
    STG_PAR1
  } stage_t;

  typedef struct packed {
    logic       shift_byte;
    logic       shift_word;
    logic [7:0] din;
  } sched_ctrl_t;

  typedef struct packed {
    logic   load;
    logic   step;
    logic   fold;
    logic   restart;
    stage_t stage;
  } comp_ctrl_t;

  localparam chain_t ChainInit = {32'hc3d2e1f0, 32'h10325476, 32'h98badcfe,
                                  32'hefcdab89, 32'h67452301};
  localparam logic [6:0] RoundLast = 7'd79;
  localparam logic [5:0] PosLast   = 6'd63;
  localparam logic [5:0] PosLenLast = 6'd55;
  localparam logic [7:0] PadMark   = 8'h80;
  localparam logic [2:0] DigestWords = 3'd5;

  function automatic logic [31:0] round_k(stage_t s);
    logic [31:0] k;
    unique case (s)
      STG_CH:   k = 32'h5a827999;
      STG_PAR0: k = 32'h6ed9eba1;
      STG_MAJ:  k = 32'h8f1bbcdc;
      STG_PAR1: k = 32'hca62c1d6;
      default:  k = 32'h5a827999;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] rol32(logic [31:0] v, logic [4:0] n);
    logic [63:0] dbl;
    dbl = {v, v} << n;
    return dbl[63:32];
  endfunction

endpackage

@@ rtl/core/sha1_sched.sv @@
// Block buffer and message schedule: a 512-bit window that takes bytes and then rolls words.
module sha1_sched (
  input  logic                 clk,
  input  sha1_pkg::sched_ctrl_t ctrl,
  output logic [31:0]          w_cur
);
  import sha1_pkg::*;

  logic [511:0] win;
  logic [31:0]  w_new;

  // Word j of the window sits at bits [511-32j -: 32]; the top word is w[i].
  assign w_cur = win[511:480];
  assign w_new = rol32(win[511-32*13 -: 32] ^ win[511-32*8 -: 32] ^
                       win[511-32*2 -: 32] ^ win[511:480], 5'd1);

  always_ff @(posedge clk) begin
    if (ctrl.shift_byte) begin
      win <= {win[503:0], ctrl.din};
    end else if (ctrl.shift_word) begin
      win <= {win[479:0], w_new};
    end
  end

endmodule

@@ rtl/core/sha1_compress.sv @@
// Chaining words, working variables and the shared SHA-1 round unit.
module sha1_compress (
  input  logic                clk,
  input  logic                rst,
  input  sha1_pkg::comp_ctrl_t ctrl,
  input  logic [31:0]         w_cur,
  output sha1_pkg::chain_t    chain
);
  import sha1_pkg::*;

  chain_t      work;
  logic [31:0] f;
  logic [31:0] t;

  always_comb begin
    unique case (ctrl.stage) inside
      STG_CH:  f = (work[1] & work[2]) | (~work[1] & work[3]);
      STG_MAJ: f = (work[1] & work[2]) | (work[1] & work[3]) | (work[2] & work[3]);
      STG_PAR0, STG_PAR1: f = work[1] ^ work[2] ^ work[3];
      default: f = work[1] ^ work[2] ^ work[3];
    endcase
  end

  assign t = rol32(work[0], 5'd5) + f + work[4] + round_k(ctrl.stage) + w_cur;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      work <= chain;
    end else if (ctrl.step) begin
      work[4] <= work[3];
      work[3] <= work[2];
      work[2] <= rol32(work[1], 5'd30);
      work[1] <= work[0];
      work[0] <= t;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain <= ChainInit;
    end else if (ctrl.restart) begin
      chain <= ChainInit;
    end else if (ctrl.fold) begin
      for (int i = 0; i < 5; i++) begin
        chain[i] <= chain[i] + work[i];
      end
    end
  end

endmodule

@@ rtl/core/sha1_stream_hasher.sv @@
// Top level of the SHA-1 stream hasher: sequencer, padding and digest output.
//
//   channel  | dir | tdata (low bit up)                        | tuser / tlast
//   s_*      | in  | data_byte[7:0]                            | tuser[0] = action
//   m_*      | out | digest_word[31:0], word_index[34:32], pad | tlast = last_word
//
// An absorb byte is shifted into the block buffer; the 64th byte of a block starts the
// rounds and then the fold. A finish pads the block up to its end, compresses it, pads
// and compresses a second block when more than 55 bytes were pending, and then loads
// the digest. Reset is synchronous. s_tready is high only while idle; the digest drains
// from its own register while absorbing goes on, and only a second finish waits for it
// to empty.
`include "sha1_stream_hasher_assert.svh"

module sha1_stream_hasher (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic [0:0]  s_tuser,   // [0] action: 0 absorb, 1 finish
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index, rest zero
  output logic        m_tlast
);
  import sha1_pkg::*;

  state_t      state;
  state_t      state_next;
  logic [5:0]  pos;
  logic [63:0] msg_bits;
  logic [6:0]  rnd;
  logic        pad_first;
  logic        tail;
  logic        fin_pend;
  logic [2:0]  out_cnt;
  chain_t      out_data;
  chain_t      chain;
  logic [31:0] w_cur;
  logic [7:0]  pad_data;
  logic        in_acc;
  logic        out_acc;
  sched_ctrl_t sc;
  comp_ctrl_t  cc;

  sha1_sched u_sched (
    .clk   (clk),
    .ctrl  (sc),
    .w_cur (w_cur)
  );

  sha1_compress u_compress (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (cc),
    .w_cur (w_cur),
    .chain (chain)
  );

  assign s_tready = (state == S_IDLE);
  assign in_acc   = s_tvalid && s_tready;
  assign m_tvalid = (out_cnt != 3'd0);
  assign out_acc  = m_tvalid && m_tready;
  assign m_tdata  = {5'd0, DigestWords - out_cnt, out_data[0]};
  assign m_tlast  = (out_cnt == 3'd1);

  // Padding byte: the end marker first, then zeros, and in the block that
  // carries the length, its eight bytes most significant first.
  always_comb begin
    if (pad_first) begin
      pad_data = PadMark;
    end else if (tail && (pos[5:3] == 3'b111)) begin
      pad_data = msg_bits[63:56];
    end else begin
      pad_data = 8'h00;
    end
  end

  always_comb begin
    state_next    = state;
    sc.shift_byte = 1'b0;
    sc.shift_word = 1'b0;
    sc.din        = pad_data;
    cc.load       = 1'b0;
    cc.step       = 1'b0;
    cc.fold       = 1'b0;
    cc.restart    = 1'b0;
    if (rnd < 7'd20) begin
      cc.stage = STG_CH;
    end else if (rnd < 7'd40) begin
      cc.stage = STG_PAR0;
    end else if (rnd < 7'd60) begin
      cc.stage = STG_MAJ;
    end else begin
      cc.stage = STG_PAR1;
    end
    unique case (state)
      S_IDLE: begin
        if (in_acc) begin
          if (s_tuser[0]) begin
            state_next = S_PAD;
          end else begin
            sc.shift_byte = 1'b1;
            sc.din        = s_tdata;
            if (pos == PosLast) begin
              cc.load    = 1'b1;
              state_next = S_ROUND;
            end
          end
        end
      end
      S_PAD: begin
        sc.shift_byte = 1'b1;
        if (pos == PosLast) begin
          cc.load    = 1'b1;
          state_next = S_ROUND;
        end
      end
      S_ROUND: begin
        sc.shift_word = 1'b1;
        cc.step       = 1'b1;
        if (rnd == RoundLast) begin
          state_next = S_FOLD;
        end
      end
      S_FOLD: begin
        cc.fold = 1'b1;
        if (!fin_pend) begin
          state_next = S_IDLE;
        end else if (tail) begin
          state_next = S_EMIT;
        end else begin
          state_next = S_PAD;
        end
      end
      S_EMIT: begin
        if (out_cnt == 3'd0) begin
          cc.restart = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pos       <= 6'd0;
      msg_bits  <= 64'd0;
      rnd       <= 7'd0;
      pad_first <= 1'b0;
      tail      <= 1'b0;
      fin_pend  <= 1'b0;
      out_cnt   <= 3'd0;
    end else begin
      state <= state_next;
      if (sc.shift_byte) begin
        pos <= pos + 6'd1;
      end
      if (in_acc && !s_tuser[0]) begin
        msg_bits <= msg_bits + 64'd8;
      end
      if (in_acc && s_tuser[0]) begin
        fin_pend  <= 1'b1;
        pad_first <= 1'b1;
      end
      if (state == S_PAD) begin
        pad_first <= 1'b0;
        if (pad_first) begin
          // The length fits behind the marker only if 55 or fewer bytes were pending.
          tail <= (pos <= PosLenLast);
        end else if (tail && (pos[5:3] == 3'b111)) begin
          msg_bits <= {msg_bits[55:0], 8'h00};
        end
      end
      if (state == S_ROUND) begin
        rnd <= (rnd == RoundLast) ? 7'd0 : rnd + 7'd1;
      end
      if ((state == S_FOLD) && fin_pend && !tail) begin
        tail <= 1'b1;
      end
      if (cc.restart) begin
        fin_pend <= 1'b0;
        tail     <= 1'b0;
        out_cnt  <= DigestWords;
      end else if (out_acc) begin
        out_cnt <= out_cnt - 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cc.restart) begin
      out_data <= chain;
    end else if (out_acc) begin
      out_data <= {32'd0, out_data[4:1]};
    end
  end

  `SHA1_ASSERT_NEXT(a_block_full, in_acc && !s_tuser[0] && (pos == PosLast),
                    state == S_ROUND, "full block did not start compression")
  `SHA1_ASSERT_NEXT(a_round_hold, (state == S_ROUND) && (rnd != RoundLast),
                    state == S_ROUND, "compression left before the last round")
  `SHA1_ASSERT_NEXT(a_emit_load, (state == S_EMIT) && (out_cnt == 3'd0),
                    (out_cnt == DigestWords) && (state == S_IDLE), "digest not loaded")
  `SHA1_ASSERT_SAME(a_len_drained, state == S_EMIT,
                    (msg_bits == 64'd0) && (pos == 6'd0), "length not fully padded")

endmodule
